// ----- hdl/pgn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_pkg
// Shared types, function codes and parameter defaults of the gradient noise
// block.
// ----------------------------------------------------------------------------
package pgn_pkg;

    localparam int TABLE_SIZE_DEF      = 256;
    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam logic [1:0] FUNC_LOAD_GRAD = 2'd0;
    localparam logic [1:0] FUNC_LOAD_PERM = 2'd1;
    localparam logic [1:0] FUNC_NOISE     = 2'd2;
    localparam logic [1:0] FUNC_TURB      = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         index;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic [7:0]         perm_x;
        logic [7:0]         perm_y;
        logic [7:0]         perm_z;
        logic [31:0]        point_x;
        logic [31:0]        point_y;
        logic [31:0]        point_z;
        logic [3:0]         octaves;
    } pgn_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/pgn_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_front
// Accepts input beats, resolves the octave count of evaluate commands and
// holds them in a two-entry queue for the evaluation engine.
// ----------------------------------------------------------------------------
module pgn_front #(
    parameter int MAX_OCTAVES = pgn_pkg::MAX_OCTAVES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pgn_pkg::pgn_cmd_t s_cmd,
    output logic                  q_valid,
    output pgn_pkg::pgn_cmd_t     q_cmd,
    input  wire logic             q_pop
);

    pgn_pkg::pgn_cmd_t entry_reg [2];
    pgn_pkg::pgn_cmd_t cls_cmd;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;

    always_comb begin
        cls_cmd = s_cmd;
        if (s_cmd.func == pgn_pkg::FUNC_NOISE) begin
            cls_cmd.octaves = 4'd1;
        end else if (s_cmd.octaves > 4'(MAX_OCTAVES)) begin
            cls_cmd.octaves = 4'(MAX_OCTAVES);
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pgn_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_back
// Holds the gradient and permutation tables and evaluates noise commands one
// octave at a time through a corner pipeline.
// ----------------------------------------------------------------------------
module pgn_back #(
    parameter int TABLE_SIZE      = pgn_pkg::TABLE_SIZE_DEF,
    parameter int COORD_FRAC_BITS = pgn_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire pgn_pkg::pgn_cmd_t q_cmd,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [23:0]     m_noise_value
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int GW     = (IDX_W > 8) ? IDX_W : 8;
    localparam int T_W    = F + 4;
    localparam int ACC_W  = F + 8;
    localparam int CONV_W = ACC_W + 8;
    localparam int SH_R   = (F >= 16) ? F - 16 : 0;
    localparam int SH_L   = (F < 16) ? 16 - F : 0;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UU   = 3'd1;
    localparam logic [2:0] ST_SM   = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OCT  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [47:0] grad_mem [TABLE_SIZE];
    logic [7:0]  permx_mem [TABLE_SIZE];
    logic [7:0]  permy_mem [TABLE_SIZE];
    logic [7:0]  permz_mem [TABLE_SIZE];

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic signed [23:0] m_value_reg, m_value_next;

    logic [31:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [3:0]  oct_cnt_reg, oct_i_reg;
    logic        turb_reg;
    logic [2:0]  c_reg;
    logic [3:0]  term_cnt_reg;
    logic signed [ACC_W-1:0] noise_sum_reg, tot_reg;

    logic [2*F-1:0] uu_x_reg, uu_y_reg, uu_z_reg;
    logic [F+1:0]   f_x_reg, f_y_reg, f_z_reg;
    logic [F:0]     s_x_reg, s_y_reg, s_z_reg;

    logic [F-1:0]     u_x, u_y, u_z;
    logic [IDX_W-1:0] xi, yi, zi;
    logic [2*F+1:0]   sp_x, sp_y, sp_z;
    logic [F:0]       one_f;

    logic [7:0]  px_rd, py_rd, pz_rd;
    logic [47:0] grad_rd;
    logic [GW-1:0] gsel, wsel;
    logic        issue;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [2:0]  cb1_reg, cb2_reg, cb3_reg, cb4_reg, cb5_reg, cb6_reg;
    logic signed [F+16:0] prx_reg, pry_reg, prz_reg;
    logic signed [F:0]    ox, oy, oz;
    logic signed [F+18:0] dsum;
    logic signed [T_W-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [F:0]           wx, wy, wz;
    logic signed [T_W+F+1:0] m1, m2, m3;

    logic signed [ACC_W-1:0]  tot_abs;
    logic signed [CONV_W-1:0] conv;
    logic signed [23:0]       sat;

    assign one_f = {1'b1, {F{1'b0}}};
    assign u_x = pt_x_reg[F-1:0];
    assign u_y = pt_y_reg[F-1:0];
    assign u_z = pt_z_reg[F-1:0];
    assign xi  = IDX_W'(pt_x_reg >> F);
    assign yi  = IDX_W'(pt_y_reg >> F);
    assign zi  = IDX_W'(pt_z_reg >> F);

    assign sp_x = uu_x_reg[2*F-1:F] * f_x_reg;
    assign sp_y = uu_y_reg[2*F-1:F] * f_y_reg;
    assign sp_z = uu_z_reg[2*F-1:F] * f_z_reg;

    assign issue = (state_reg == ST_RUN);
    assign gsel  = GW'(px_rd ^ py_rd ^ pz_rd);
    assign wsel  = GW'(q_cmd.index);

    assign q_pop = (state_reg == ST_IDLE) && q_valid &&
                   ((q_cmd.func == pgn_pkg::FUNC_LOAD_GRAD) ||
                    (q_cmd.func == pgn_pkg::FUNC_LOAD_PERM) || !m_valid_reg);

    // Table writes and registered table reads.
    always_ff @(posedge aclk) begin
        if (q_pop && (q_cmd.func == pgn_pkg::FUNC_LOAD_GRAD)) begin
            grad_mem[wsel[IDX_W-1:0]] <= {q_cmd.grad_x, q_cmd.grad_y, q_cmd.grad_z};
        end
        if (q_pop && (q_cmd.func == pgn_pkg::FUNC_LOAD_PERM)) begin
            permx_mem[wsel[IDX_W-1:0]] <= q_cmd.perm_x;
            permy_mem[wsel[IDX_W-1:0]] <= q_cmd.perm_y;
            permz_mem[wsel[IDX_W-1:0]] <= q_cmd.perm_z;
        end
        px_rd   <= permx_mem[xi + IDX_W'(c_reg[0])];
        py_rd   <= permy_mem[yi + IDX_W'(c_reg[1])];
        pz_rd   <= permz_mem[zi + IDX_W'(c_reg[2])];
        grad_rd <= grad_mem[gsel[IDX_W-1:0]];
    end

    always_comb begin
        ox = cb2_reg[0] ? $signed({1'b1, u_x}) : $signed({1'b0, u_x});
        oy = cb2_reg[1] ? $signed({1'b1, u_y}) : $signed({1'b0, u_y});
        oz = cb2_reg[2] ? $signed({1'b1, u_z}) : $signed({1'b0, u_z});
        dsum = {{2{prx_reg[F+16]}}, prx_reg} + {{2{pry_reg[F+16]}}, pry_reg}
             + {{2{prz_reg[F+16]}}, prz_reg};
        wx = cb4_reg[0] ? s_x_reg : one_f - s_x_reg;
        wy = cb5_reg[1] ? s_y_reg : one_f - s_y_reg;
        wz = cb6_reg[2] ? s_z_reg : one_f - s_z_reg;
        m1 = t0_reg * $signed({1'b0, wx});
        m2 = t1_reg * $signed({1'b0, wy});
        m3 = t2_reg * $signed({1'b0, wz});
    end

    // Corner pipeline payload.
    always_ff @(posedge aclk) begin
        cb1_reg <= c_reg;
        cb2_reg <= cb1_reg;
        cb3_reg <= cb2_reg;
        cb4_reg <= cb3_reg;
        cb5_reg <= cb4_reg;
        cb6_reg <= cb5_reg;
        prx_reg <= $signed(grad_rd[47:32]) * ox;
        pry_reg <= $signed(grad_rd[31:16]) * oy;
        prz_reg <= $signed(grad_rd[15:0]) * oz;
        t0_reg  <= dsum[F+18:15];
        t1_reg  <= m1[F+T_W-1:F];
        t2_reg  <= m2[F+T_W-1:F];
        t3_reg  <= m3[F+T_W-1:F];
        if (state_reg == ST_UU) begin
            uu_x_reg <= u_x * u_x;
            uu_y_reg <= u_y * u_y;
            uu_z_reg <= u_z * u_z;
            f_x_reg  <= {2'b11, {F{1'b0}}} - {1'b0, u_x, 1'b0};
            f_y_reg  <= {2'b11, {F{1'b0}}} - {1'b0, u_y, 1'b0};
            f_z_reg  <= {2'b11, {F{1'b0}}} - {1'b0, u_z, 1'b0};
        end
        if (state_reg == ST_SM) begin
            s_x_reg <= sp_x[2*F:F];
            s_y_reg <= sp_y[2*F:F];
            s_z_reg <= sp_z[2*F:F];
        end
    end

    always_comb begin
        tot_abs = (turb_reg && tot_reg[ACC_W-1]) ? -tot_reg : tot_reg;
        conv = ($signed({{(CONV_W-ACC_W){tot_abs[ACC_W-1]}}, tot_abs}) >>> SH_R) <<< SH_L;
        if (conv > $signed({{(CONV_W-24){1'b0}}, 24'h7FFFFF})) begin
            sat = 24'sh7FFFFF;
        end else if (conv < $signed({{(CONV_W-24){1'b1}}, 24'h800000})) begin
            sat = -24'sh800000;
        end else begin
            sat = conv[23:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop && ((q_cmd.func == pgn_pkg::FUNC_NOISE) ||
                              (q_cmd.func == pgn_pkg::FUNC_TURB))) begin
                    if (q_cmd.octaves == 4'd0) begin
                        m_valid_next = 1'b1;
                        m_value_next = '0;
                    end else begin
                        state_next = ST_UU;
                    end
                end
            end
            ST_UU:   state_next = ST_SM;
            ST_SM:   state_next = ST_RUN;
            ST_RUN: begin
                if (c_reg == 3'd7) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (term_cnt_reg == 4'd8) begin
                    state_next = ST_OCT;
                end
            end
            ST_OCT: begin
                state_next = (oct_i_reg + 4'd1 == oct_cnt_reg) ? ST_OUT : ST_UU;
            end
            ST_OUT: begin
                m_valid_next = 1'b1;
                m_value_next = sat;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            c_reg        <= 3'd0;
            term_cnt_reg <= 4'd0;
            oct_i_reg    <= 4'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            v1_reg      <= issue;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            if (state_reg == ST_SM) begin
                c_reg        <= 3'd0;
                term_cnt_reg <= 4'd0;
            end else begin
                if (issue) begin
                    c_reg <= c_reg + 3'd1;
                end
                if (v7_reg) begin
                    term_cnt_reg <= term_cnt_reg + 4'd1;
                end
            end
            if (state_reg == ST_IDLE) begin
                oct_i_reg <= 4'd0;
            end else if (state_reg == ST_OCT) begin
                oct_i_reg <= oct_i_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        if (state_reg == ST_IDLE) begin
            pt_x_reg    <= q_cmd.point_x;
            pt_y_reg    <= q_cmd.point_y;
            pt_z_reg    <= q_cmd.point_z;
            oct_cnt_reg <= q_cmd.octaves;
            turb_reg    <= (q_cmd.func == pgn_pkg::FUNC_TURB);
            tot_reg     <= '0;
        end
        if (state_reg == ST_SM) begin
            noise_sum_reg <= '0;
        end else if (v7_reg) begin
            noise_sum_reg <= noise_sum_reg + {{(ACC_W-T_W){t3_reg[T_W-1]}}, t3_reg};
        end
        if (state_reg == ST_OCT) begin
            tot_reg  <= tot_reg + (noise_sum_reg >>> oct_i_reg);
            pt_x_reg <= pt_x_reg << 1;
            pt_y_reg <= pt_y_reg << 1;
            pt_z_reg <= pt_z_reg << 1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_value_reg;

endmodule
`default_nettype wire

// ----- hdl/perlin_gradient_noise.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_gradient_noise
// Three-dimensional gradient noise and turbulence with loadable tables.
// ----------------------------------------------------------------------------
// Load beats write one gradient or permutation entry in the engine. A noise
// beat runs through these steps before its result appears: the engine takes
// the command, does the smoothing multiplies, issues eight corners through the
// table reads, drains the seven-stage pipeline until the last term is seen,
// and folds and emits the result. A turbulence beat repeats the smoothing,
// issue, drain and fold steps for every octave; with no octaves it yields a
// zero result. Corners issue one per cycle. A two-entry queue keeps accepting
// beats while it has room and the engine is busy or a result waits to be
// taken; the next noise or turbulence beat starts only once that result is
// taken.
module perlin_gradient_noise #(
    parameter int TABLE_SIZE      = pgn_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES     = pgn_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = pgn_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [7:0]         s_index,
    input  wire logic signed [15:0] s_grad_x,
    input  wire logic signed [15:0] s_grad_y,
    input  wire logic signed [15:0] s_grad_z,
    input  wire logic [7:0]         s_perm_x,
    input  wire logic [7:0]         s_perm_y,
    input  wire logic [7:0]         s_perm_z,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_point_z,
    input  wire logic [3:0]         s_octaves,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [23:0]      m_noise_value
);

    pgn_pkg::pgn_cmd_t s_cmd, q_cmd;
    logic q_valid, q_pop;

    always_comb begin
        s_cmd.func    = s_func;
        s_cmd.index   = s_index;
        s_cmd.grad_x  = s_grad_x;
        s_cmd.grad_y  = s_grad_y;
        s_cmd.grad_z  = s_grad_z;
        s_cmd.perm_x  = s_perm_x;
        s_cmd.perm_y  = s_perm_y;
        s_cmd.perm_z  = s_perm_z;
        s_cmd.point_x = s_point_x;
        s_cmd.point_y = s_point_y;
        s_cmd.point_z = s_point_z;
        s_cmd.octaves = s_octaves;
    end

    pgn_front #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd  (s_cmd),
        .q_valid(q_valid),
        .q_cmd  (q_cmd),
        .q_pop  (q_pop)
    );

    pgn_back #(
        .TABLE_SIZE     (TABLE_SIZE),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_noise_value(m_noise_value)
    );

    // The engine never takes a command from an empty queue.
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Reset leaves no result pending and the queue open.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("reset did not clear the result or the queue");

    // A new result is only produced while no earlier beat is waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending result dropped");

endmodule
`default_nettype wire

// ----- tb/perlin_gradient_noise_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perlin_gradient_noise_checker
// Watches both channels of the gradient noise block, mirrors its tables,
// predicts each noise or turbulence value and compares it with the output.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [7:0]         s_index,
    input  wire logic signed [15:0] s_grad_x,
    input  wire logic signed [15:0] s_grad_y,
    input  wire logic signed [15:0] s_grad_z,
    input  wire logic [7:0]         s_perm_x,
    input  wire logic [7:0]         s_perm_y,
    input  wire logic [7:0]         s_perm_z,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_point_z,
    input  wire logic [3:0]         s_octaves,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [23:0] m_noise_value,
    output int                      error_count,
    output int                      pending_count,
    output int                      values_checked
);

    localparam int FB = pgn_pkg::COORD_FRAC_BITS_DEF;
    localparam longint ONE_F = longint'(1) << FB;

    logic signed [15:0] grad_mem [256][3];
    logic [7:0] px_mem [256];
    logic [7:0] py_mem [256];
    logic [7:0] pz_mem [256];
    logic signed [23:0] expected_values [$];

    function automatic longint hermite(longint u);
        longint u2;
        u2 = (u * u) >>> FB;
        return (u2 * (3 * ONE_F - 2 * u)) >>> FB;
    endfunction

    function automatic longint lattice_noise(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz);
        logic [7:0] xi, yi, zi, g;
        longint u, v, w, su, sv, sw, ox, oy, oz, wx, wy, wz, t, sum;
        int a, b, d;
        xi = px[FB+7:FB];
        yi = py[FB+7:FB];
        zi = pz[FB+7:FB];
        u = longint'(px[FB-1:0]);
        v = longint'(py[FB-1:0]);
        w = longint'(pz[FB-1:0]);
        su = hermite(u);
        sv = hermite(v);
        sw = hermite(w);
        sum = 0;
        for (int c = 0; c < 8; c++) begin
            a = c & 1;
            b = (c >> 1) & 1;
            d = (c >> 2) & 1;
            g = px_mem[8'(xi + a)] ^ py_mem[8'(yi + b)] ^ pz_mem[8'(zi + d)];
            ox = a ? u - ONE_F : u;
            oy = b ? v - ONE_F : v;
            oz = d ? w - ONE_F : w;
            wx = a ? su : ONE_F - su;
            wy = b ? sv : ONE_F - sv;
            wz = d ? sw : ONE_F - sw;
            t = longint'(grad_mem[g][0]) * ox + longint'(grad_mem[g][1]) * oy
                + longint'(grad_mem[g][2]) * oz;
            t = t >>> 15;
            t = (t * wx) >>> FB;
            t = (t * wy) >>> FB;
            t = (t * wz) >>> FB;
            sum += t;
        end
        return sum;
    endfunction

    function automatic logic signed [23:0] clamp_q16(longint q);
        longint r;
        r = q >>> (FB - 16);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    function automatic logic signed [23:0] turbulence(logic [31:0] px,
            logic [31:0] py, logic [31:0] pz, logic [3:0] oct);
        longint acc;
        int n;
        acc = 0;
        n = (oct > pgn_pkg::MAX_OCTAVES_DEF) ? pgn_pkg::MAX_OCTAVES_DEF : oct;
        for (int i = 0; i < n; i++) begin
            acc += lattice_noise(px, py, pz) >>> i;
            px = px << 1;
            py = py << 1;
            pz = pz << 1;
        end
        if (acc < 0) acc = -acc;
        return clamp_q16(acc);
    endfunction

    assign pending_count = expected_values.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_values.delete();
            error_count <= 0;
            values_checked <= 0;
        end else begin
            if (s_valid && s_ready) begin
                case (s_func)
                    pgn_pkg::FUNC_LOAD_GRAD: begin
                        grad_mem[s_index][0] = s_grad_x;
                        grad_mem[s_index][1] = s_grad_y;
                        grad_mem[s_index][2] = s_grad_z;
                    end
                    pgn_pkg::FUNC_LOAD_PERM: begin
                        px_mem[s_index] = s_perm_x;
                        py_mem[s_index] = s_perm_y;
                        pz_mem[s_index] = s_perm_z;
                    end
                    pgn_pkg::FUNC_NOISE: begin
                        expected_values.push_back(
                            clamp_q16(lattice_noise(s_point_x, s_point_y, s_point_z)));
                    end
                    default: begin
                        expected_values.push_back(
                            turbulence(s_point_x, s_point_y, s_point_z, s_octaves));
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                values_checked <= values_checked + 1;
                if (expected_values.size() == 0) begin
                    if (error_count < 10)
                        $display("unexpected output beat: %0d", m_noise_value);
                    error_count <= error_count + 1;
                end else begin
                    if (m_noise_value !== expected_values[0]) begin
                        if (error_count < 10)
                            $display("noise_value mismatch: expected %0d, got %0d",
                                     expected_values[0], m_noise_value);
                        error_count <= error_count + 1;
                    end
                    void'(expected_values.pop_front());
                end
            end
        end
    end
endmodule

// ----- tb/perlin_gradient_noise_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perlin_gradient_noise_tb
// Fills the gradient and permutation tables completely, then sends directed
// and random noise, turbulence and load beats with random gaps and output stalls.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_tb;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = pgn_pkg::FUNC_LOAD_GRAD;
    logic [7:0] s_index = '0;
    logic signed [15:0] s_grad_x = '0, s_grad_y = '0, s_grad_z = '0;
    logic [7:0] s_perm_x = '0, s_perm_y = '0, s_perm_z = '0;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic [3:0] s_octaves = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_noise_value;
    int error_count, pending_count, values_checked;
    bit calm_stretch = 1'b0;
    int sent_count = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    perlin_gradient_noise dut (.*);

    perlin_gradient_noise_checker checker_i (.*);

    always @(posedge aclk) begin
        m_ready <= calm_stretch || ($urandom_range(99) >= 27);
    end

    // The valid line stays high from one accepted beat into the next unless
    // an idle cycle comes between them.
    task automatic send_beat(logic [1:0] func, logic [7:0] idx, logic [47:0] grad,
                             logic [23:0] perm, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [3:0] oct);
        while (!calm_stretch && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_index <= idx;
        {s_grad_x, s_grad_y, s_grad_z} <= grad;
        {s_perm_x, s_perm_y, s_perm_z} <= perm;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        s_octaves <= oct;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    function automatic logic [31:0] random_point();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{12{$urandom_range(1)==1}}, 4'($urandom), 16'($urandom)};
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return {16'($urandom), $urandom_range(1) ? 16'hffff : 16'h0000};
        endcase
    endfunction

    initial begin
        logic [31:0] edge_pts [6];
        edge_pts = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                     32'h0000ffff, 32'h00010000};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 256; i++) begin
            logic [47:0] g;
            g = {$urandom, 16'($urandom)};
            if (i == 0) g = {16'h7fff, 16'h7fff, 16'h7fff};
            if (i == 1) g = {16'h8000, 16'h8000, 16'h8000};
            send_beat(pgn_pkg::FUNC_LOAD_GRAD, 8'(i), g, '0, '0, '0, '0, '0);
            send_beat(pgn_pkg::FUNC_LOAD_PERM, 8'(i), '0, 24'($urandom), '0, '0, '0, '0);
        end
        // Extreme points, every octave count including ones above the limit.
        for (int i = 0; i < 6; i++)
            send_beat(pgn_pkg::FUNC_NOISE, '0, '0, '0, edge_pts[i], edge_pts[5 - i],
                      edge_pts[(i + 2) % 6], '0);
        for (int o = 0; o < 16; o++)
            send_beat(pgn_pkg::FUNC_TURB, '0, '0, '0, edge_pts[o % 6],
                      edge_pts[(o + 1) % 6], edge_pts[(o + 3) % 6], 4'(o));
        // Make the saturating entries dominate and force large sums.
        send_beat(pgn_pkg::FUNC_LOAD_PERM, 8'd5, '0, 24'h000000, '0, '0, '0, '0);
        send_beat(pgn_pkg::FUNC_NOISE, '0, '0, '0, 32'h00057fff, 32'h00058000,
                  32'h00050000, '0);
        for (int n = 0; n < 310; n++) begin
            calm_stretch = (n >= 100 && n < 180);
            case ($urandom_range(9))
                0: send_beat(pgn_pkg::FUNC_LOAD_GRAD, 8'($urandom),
                             {$urandom, 16'($urandom)}, '0, '0, '0, '0, '0);
                1: send_beat(pgn_pkg::FUNC_LOAD_PERM, 8'($urandom), '0, 24'($urandom),
                             '0, '0, '0, '0);
                2, 3, 4, 5: send_beat(pgn_pkg::FUNC_NOISE, 8'($urandom), '0, '0,
                                      random_point(), random_point(), random_point(),
                                      4'($urandom));
                default: send_beat(pgn_pkg::FUNC_TURB, 8'($urandom), '0, '0,
                                   random_point(), random_point(), random_point(),
                                   ($urandom_range(9) == 0) ? 4'($urandom)
                                                            : 4'($urandom_range(4)));
            endcase
        end
        s_valid <= 1'b0;
        calm_stretch = 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d beats including full table loads; %0d noise and turbulence",
                 sent_count, values_checked);
        $display("values checked, with extreme points and octave counts 0 to 15.");
        if (error_count == 0) begin
            $display("perlin_gradient_noise_tb: clean");
        end else begin
            $display("perlin_gradient_noise_tb: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("perlin_gradient_noise_tb: errors");
        $finish;
    end
endmodule
